>>> rtl/qsfp_pkg.sv
// shared types and constants for the query string field parser
package qsfp_pkg;

  // result kinds
  localparam logic [1:0] KIND_BEGIN   = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_NUMBERS = 2'd2;

  // parameter kinds of the current piece
  localparam logic [3:0] PK_NONE    = 4'd0;
  localparam logic [3:0] PK_LIMIT   = 4'd1;
  localparam logic [3:0] PK_OFFSET  = 4'd2;
  localparam logic [3:0] PK_ID      = 4'd3;
  localparam logic [3:0] PK_MULTI   = 4'd4;
  localparam logic [3:0] PK_KEY     = 4'd5;
  localparam logic [3:0] PK_VALUE   = 4'd6;
  localparam logic [3:0] PK_ORDERBY = 4'd7;
  localparam logic [3:0] PK_SORT    = 4'd8;

  // separators
  localparam logic [7:0] CH_AMP = 8'h26;
  localparam logic [7:0] CH_EQ  = 8'h3d;

  // name capacity; a name length of NAME_LONG marks a name that is too long
  localparam logic [3:0] NAME_MAX  = 4'd7;
  localparam logic [3:0] NAME_LONG = 4'd8;

  // recognized names, last byte in the low bits
  localparam logic [39:0] NAME_LIMIT   = "limit";
  localparam logic [47:0] NAME_OFFSET  = "offset";
  localparam logic [15:0] NAME_ID      = "id";
  localparam logic [39:0] NAME_MULTI   = "multi";
  localparam logic [23:0] NAME_KEY     = "key";
  localparam logic [39:0] NAME_VALUE   = "value";
  localparam logic [55:0] NAME_ORDERBY = "orderby";
  localparam logic [31:0] NAME_SORT    = "sort";

  // configuration register indexes and reset values
  localparam logic       CFG_DEFAULT_LIMIT = 1'b0;
  localparam logic       CFG_DEFAULT_MULTI = 1'b1;
  localparam logic [31:0] RST_DEFAULT_LIMIT = 32'd10;
  localparam logic [31:0] RST_DEFAULT_MULTI = 32'd1;

  // output queue depth
  localparam int unsigned FIFO_DEPTH = 4;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  which_string;
    logic [7:0]  text_byte;
    logic [63:0] id_val;
    logic [63:0] offset_val;
    logic [31:0] limit_val;
    logic [31:0] multi_val;
    logic        last;
  } result_t;

  // control from the parser to the number accumulator
  typedef struct packed {
    logic       feed;
    logic       clear;
    logic [7:0] ch;
  } num_ctrl_t;

  // numbers seen by the parser, after the current byte
  typedef struct packed {
    logic [31:0] signed_val;
    logic [63:0] unsigned_val;
  } num_res_t;

endpackage

>>> rtl/qsfp_in_if.sv
// input request channel: one query byte with its flags
interface qsfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       end_of_query;

  modport source (output valid, output ch, output has_char, output end_of_query,
                  input ready);
  modport sink   (input valid, input ch, input has_char, input end_of_query,
                  output ready);
endinterface

>>> rtl/qsfp_out_if.sv
// result request channel: string markers, string bytes and final numbers
interface qsfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  which_string;
  logic [7:0]  text_byte;
  logic [63:0] id_out;
  logic [63:0] offset_out;
  logic [31:0] limit_out;
  logic [31:0] multi_out;
  logic        last_of_run;

  modport source (output valid, output kind, output which_string, output text_byte,
                  output id_out, output offset_out, output limit_out, output multi_out,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input which_string, input text_byte,
                  input id_out, input offset_out, input limit_out, input multi_out,
                  input last_of_run, output ready);
endinterface

>>> rtl/qsfp_number.sv
// decimal number accumulator with strtol / strtoull style results
module qsfp_number (
  input  logic                clk,
  input  logic                rst_n,
  input  qsfp_pkg::num_ctrl_t ctrl,
  output qsfp_pkg::num_res_t  res
);

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_STOP   = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic        ovf_r, ovf_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic [63:0] negmag_r, negmag_nxt;   // two's complement negation of mag_r, kept alongside

  logic        is_digit;
  logic        is_space;
  logic        is_sign;
  logic        accum;
  logic [63:0] dig;
  logic [67:0] prod;
  logic [63:0] negprod;

  // byte classes
  always_comb begin
    is_digit = (ctrl.ch >= 8'h30) && (ctrl.ch <= 8'h39);
    is_space = (ctrl.ch == 8'h20) || ((ctrl.ch >= 8'h09) && (ctrl.ch <= 8'h0d));
    is_sign  = (ctrl.ch == 8'h2b) || (ctrl.ch == 8'h2d);
    dig      = {60'd0, ctrl.ch[3:0]};
  end

  // times ten plus digit, positive and negated forms in parallel
  always_comb begin
    prod    = ({4'd0, mag_r} << 3) + ({4'd0, mag_r} << 1) + {4'd0, dig};
    negprod = (negmag_r << 3) + (negmag_r << 1) - dig;
  end

  // phase sequencing for one value byte
  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    ovf_nxt    = ovf_r;
    mag_nxt    = mag_r;
    negmag_nxt = negmag_r;
    accum      = 1'b0;
    if (ctrl.feed) begin
      unique case (phase_r)
        PH_SKIP: begin
          if (is_space) begin
            phase_nxt = PH_SKIP;
          end else if (is_sign) begin
            neg_nxt   = (ctrl.ch == 8'h2d);
            phase_nxt = PH_SIGN;
          end else begin
            phase_nxt = is_digit ? PH_DIGITS : PH_STOP;
            accum     = is_digit;
          end
        end
        PH_SIGN: begin
          phase_nxt = is_digit ? PH_DIGITS : PH_STOP;
          accum     = is_digit;
        end
        PH_DIGITS: begin
          phase_nxt = is_digit ? PH_DIGITS : PH_STOP;
          accum     = is_digit;
        end
        PH_STOP: begin
          phase_nxt = PH_STOP;
        end
        default: begin
          phase_nxt = PH_STOP;
        end
      endcase
    end
    if (accum) begin
      if (prod[67:64] != 4'd0) begin
        ovf_nxt = 1'b1;
      end else begin
        mag_nxt    = prod[63:0];
        negmag_nxt = negprod;
      end
    end
  end

  // results after this byte
  always_comb begin
    if (neg_nxt) begin
      if (ovf_nxt || (mag_nxt[63] && (mag_nxt[62:0] != 63'd0))) begin
        res.signed_val = 32'd0;
      end else begin
        res.signed_val = negmag_nxt[31:0];
      end
    end else begin
      if (ovf_nxt || mag_nxt[63]) begin
        res.signed_val = 32'hffff_ffff;
      end else begin
        res.signed_val = mag_nxt[31:0];
      end
    end
    if (ovf_nxt) begin
      res.unsigned_val = 64'hffff_ffff_ffff_ffff;
    end else begin
      res.unsigned_val = neg_nxt ? negmag_nxt : mag_nxt;
    end
  end

  // state, cleared at the end of each piece
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      phase_r  <= PH_SKIP;
      neg_r    <= 1'b0;
      ovf_r    <= 1'b0;
      mag_r    <= 64'd0;
      negmag_r <= 64'd0;
    end else begin
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      ovf_r    <= ovf_nxt;
      mag_r    <= mag_nxt;
      negmag_r <= negmag_nxt;
    end
  end

endmodule

>>> rtl/qsfp_out_fifo.sv
// small result queue that takes up to two results per cycle
module qsfp_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        wr_n,
  input  qsfp_pkg::result_t wr0,
  input  qsfp_pkg::result_t wr1,
  output logic              room,
  qsfp_out_if.source        out
);

  localparam int unsigned PW = $clog2(qsfp_pkg::FIFO_DEPTH);

  qsfp_pkg::result_t mem [qsfp_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          pop;
  logic [PW-1:0] wr_ptr_p1;
  qsfp_pkg::result_t head;

  // pointer and count updates
  always_comb begin
    pop        = (count_r != '0) && out.ready;
    wr_ptr_p1  = wr_ptr_r + PW'(1);
    wr_ptr_nxt = wr_ptr_r + PW'(wr_n);
    rd_ptr_nxt = rd_ptr_r + PW'(pop);
    count_nxt  = count_r + (PW+1)'(wr_n) - (PW+1)'(pop);
    room       = count_r <= (PW+1)'(qsfp_pkg::FIFO_DEPTH - 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage writes
  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) begin
      mem[wr_ptr_r] <= wr0;
    end
    if (wr_n == 2'd2) begin
      mem[wr_ptr_p1] <= wr1;
    end
  end

  // head of queue drives the channel
  assign head             = mem[rd_ptr_r];
  assign out.valid        = (count_r != '0);
  assign out.kind         = head.kind;
  assign out.which_string = head.which_string;
  assign out.text_byte    = head.text_byte;
  assign out.id_out       = head.id_val;
  assign out.offset_out   = head.offset_val;
  assign out.limit_out    = head.limit_val;
  assign out.multi_out    = head.multi_val;
  assign out.last_of_run  = head.last;

endmodule

>>> rtl/query_string_field_parser.sv
// Query string field parser: byte requests into string and number results.
// Path: a byte is registered at the input, then written into the result queue.
// Throughput: one byte per cycle while the queue has room; a byte that ends the query
//   while giving a string result yields two results, written at once (4-entry queue).
// Reset: synchronous active-low rst_n; defaults return to limit 10, multi 1, queue empties.
module query_string_field_parser (
  input  logic        clk,
  input  logic        rst_n,
  qsfp_in_if.sink     in_chan,
  qsfp_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  // input register
  logic       in_vld_r;
  logic [7:0] ch_r;
  logic       has_r;
  logic       fin_r;

  // piece state
  logic [55:0] name_r, name_nxt;
  logic [3:0]  len_r, len_nxt;
  logic        iv_r, iv_nxt, iv_eff;
  logic [3:0]  pk_r, pk_nxt, pk_eff;

  // held results and defaults
  logic [31:0] def_limit_r, def_multi_r;
  logic [31:0] held_limit_r, held_limit_nxt, upd_limit;
  logic [31:0] held_multi_r, held_multi_nxt, upd_multi;
  logic [63:0] held_id_r, held_id_nxt, upd_id;
  logic [63:0] held_offset_r, held_offset_nxt, upd_offset;

  logic        room;
  logic        consume;
  logic        byte_ok;
  logic        fin_ok;
  logic        end_piece;
  logic        emit_txt;
  logic [3:0]  klass;
  logic [3:0]  which_full;
  logic [1:0]  wr_n;
  qsfp_pkg::result_t txt_res, num_res_item, wr0, wr1;
  qsfp_pkg::num_ctrl_t num_ctrl;
  qsfp_pkg::num_res_t  num_res;

  // input request handshake
  assign consume       = in_vld_r && room;
  assign in_chan.ready = !in_vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      ch_r  <= in_chan.ch;
      has_r <= in_chan.has_char;
      fin_r <= in_chan.end_of_query;
    end
  end

  // name lookup
  always_comb begin
    if (len_r == 4'd5 && name_r[39:0] == qsfp_pkg::NAME_LIMIT) begin
      klass = qsfp_pkg::PK_LIMIT;
    end else if (len_r == 4'd6 && name_r[47:0] == qsfp_pkg::NAME_OFFSET) begin
      klass = qsfp_pkg::PK_OFFSET;
    end else if (len_r == 4'd2 && name_r[15:0] == qsfp_pkg::NAME_ID) begin
      klass = qsfp_pkg::PK_ID;
    end else if (len_r == 4'd5 && name_r[39:0] == qsfp_pkg::NAME_MULTI) begin
      klass = qsfp_pkg::PK_MULTI;
    end else if (len_r == 4'd3 && name_r[23:0] == qsfp_pkg::NAME_KEY) begin
      klass = qsfp_pkg::PK_KEY;
    end else if (len_r == 4'd5 && name_r[39:0] == qsfp_pkg::NAME_VALUE) begin
      klass = qsfp_pkg::PK_VALUE;
    end else if (len_r == 4'd7 && name_r[55:0] == qsfp_pkg::NAME_ORDERBY) begin
      klass = qsfp_pkg::PK_ORDERBY;
    end else if (len_r == 4'd4 && name_r[31:0] == qsfp_pkg::NAME_SORT) begin
      klass = qsfp_pkg::PK_SORT;
    end else begin
      klass = qsfp_pkg::PK_NONE;
    end
  end

  // byte handling
  always_comb begin
    byte_ok       = consume && has_r;
    fin_ok        = consume && fin_r;
    name_nxt      = name_r;
    len_nxt       = len_r;
    iv_eff        = iv_r;
    pk_eff        = pk_r;
    emit_txt      = 1'b0;
    num_ctrl.feed = 1'b0;
    num_ctrl.ch   = ch_r;
    txt_res       = '0;
    end_piece     = fin_ok;
    if (byte_ok) begin
      if (ch_r == qsfp_pkg::CH_AMP) begin
        end_piece = 1'b1;
      end else if (!iv_r) begin
        if (ch_r == qsfp_pkg::CH_EQ) begin
          iv_eff = 1'b1;
          pk_eff = klass;
          if (klass >= qsfp_pkg::PK_KEY) begin
            emit_txt     = 1'b1;
            txt_res.kind = qsfp_pkg::KIND_BEGIN;
          end
        end else if (len_r < qsfp_pkg::NAME_MAX) begin
          name_nxt = {name_r[47:0], ch_r};
          len_nxt  = len_r + 4'd1;
        end else begin
          len_nxt = qsfp_pkg::NAME_LONG;
        end
      end else if (pk_r >= qsfp_pkg::PK_KEY) begin
        emit_txt          = 1'b1;
        txt_res.kind      = qsfp_pkg::KIND_BYTE;
        txt_res.text_byte = ch_r;
      end else if (pk_r != qsfp_pkg::PK_NONE) begin
        num_ctrl.feed = 1'b1;
      end
    end
    which_full           = pk_eff - qsfp_pkg::PK_KEY;
    txt_res.which_string = which_full[1:0];
    txt_res.last         = !fin_ok;
    num_ctrl.clear       = end_piece;
    iv_nxt               = end_piece ? 1'b0 : iv_eff;
    pk_nxt               = end_piece ? qsfp_pkg::PK_NONE : pk_eff;
    if (end_piece) begin
      len_nxt = 4'd0;
    end
  end

  qsfp_number u_number (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (num_ctrl),
    .res   (num_res)
  );

  // held numbers at the end of a piece
  always_comb begin
    upd_limit  = held_limit_r;
    upd_multi  = held_multi_r;
    upd_id     = held_id_r;
    upd_offset = held_offset_r;
    if (end_piece && iv_eff) begin
      case (pk_eff)
        qsfp_pkg::PK_LIMIT:  upd_limit  = num_res.signed_val;
        qsfp_pkg::PK_OFFSET: upd_offset = num_res.unsigned_val;
        qsfp_pkg::PK_ID:     upd_id     = num_res.unsigned_val;
        qsfp_pkg::PK_MULTI:  upd_multi  = num_res.signed_val;
        default: begin
        end
      endcase
    end
    held_limit_nxt  = fin_ok ? def_limit_r : upd_limit;
    held_multi_nxt  = fin_ok ? def_multi_r : upd_multi;
    held_id_nxt     = fin_ok ? 64'd0 : upd_id;
    held_offset_nxt = fin_ok ? 64'd0 : upd_offset;
  end

  // result assembly
  always_comb begin
    num_res_item            = '0;
    num_res_item.kind       = qsfp_pkg::KIND_NUMBERS;
    num_res_item.id_val     = upd_id;
    num_res_item.offset_val = upd_offset;
    num_res_item.limit_val  = upd_limit;
    num_res_item.multi_val  = upd_multi;
    num_res_item.last       = 1'b1;
    wr0  = txt_res;
    wr1  = num_res_item;
    wr_n = 2'd0;
    if (emit_txt) begin
      wr_n = fin_ok ? 2'd2 : 2'd1;
    end else if (fin_ok) begin
      wr0  = num_res_item;
      wr_n = 2'd1;
    end
  end

  qsfp_out_fifo u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_n  (wr_n),
    .wr0   (wr0),
    .wr1   (wr1),
    .room  (room),
    .out   (out_chan)
  );

  // control state and held values; configuration writes load defaults and held copies
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r         <= 4'd0;
      iv_r          <= 1'b0;
      pk_r          <= qsfp_pkg::PK_NONE;
      def_limit_r   <= qsfp_pkg::RST_DEFAULT_LIMIT;
      def_multi_r   <= qsfp_pkg::RST_DEFAULT_MULTI;
      held_limit_r  <= qsfp_pkg::RST_DEFAULT_LIMIT;
      held_multi_r  <= qsfp_pkg::RST_DEFAULT_MULTI;
      held_id_r     <= 64'd0;
      held_offset_r <= 64'd0;
    end else begin
      len_r         <= len_nxt;
      iv_r          <= iv_nxt;
      pk_r          <= pk_nxt;
      held_id_r     <= held_id_nxt;
      held_offset_r <= held_offset_nxt;
      held_limit_r  <= held_limit_nxt;
      held_multi_r  <= held_multi_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          qsfp_pkg::CFG_DEFAULT_LIMIT: begin
            def_limit_r  <= cfg_wdata;
            held_limit_r <= cfg_wdata;
          end
          qsfp_pkg::CFG_DEFAULT_MULTI: begin
            def_multi_r  <= cfg_wdata;
            held_multi_r <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // name shift line, only bytes of the current piece are compared
  always_ff @(posedge clk) begin
    name_r <= name_nxt;
  end

endmodule
